### design/arp_pkg.sv
`timescale 1ns / 1ps

package arp_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int SLOT_W  = 4;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic OP_LEARN  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic             op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

### design/arp_queue.sv
`timescale 1ns / 1ps

module arp_queue
  import arp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     pop_item,
  output q_status_t status
);

  item_t             slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_item     = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### design/arp_front.sv
`timescale 1ns / 1ps

module arp_front
  import arp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_kind,
  input  logic [IP_W-1:0]  in_ip_addr,
  input  logic [MAC_W-1:0] in_mac_addr,
  input  q_status_t        q_status,
  output logic             q_push,
  output item_t            q_item
);

  logic  hold_vld_r, hold_vld_nxt;
  item_t hold_r;
  logic  accept;

  assign busy   = hold_vld_r && q_status.full;
  assign accept = start && !busy;
  assign q_push = hold_vld_r && !q_status.full;
  assign q_item = hold_r;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (accept) begin
      hold_vld_nxt = 1'b1;
    end else if (q_push) begin
      hold_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r.op  <= in_kind ? OP_LOOKUP : OP_LEARN;
      hold_r.ip  <= in_ip_addr;
      hold_r.mac <= in_mac_addr;
    end
  end

endmodule

### design/arp_back.sv
`timescale 1ns / 1ps

module arp_back
  import arp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  q_status_t         q_status,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              out_valid,
  output logic              out_found,
  output logic [MAC_W-1:0]  out_mac_result,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_evicted
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MAC   = 3'd4;

  logic [2:0]         state_r, state_nxt;
  item_t              item_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic               free_r, free_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [IP_W-1:0]    ip_rd_r;
  logic [MAC_W-1:0]   mac_rd_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [MAC_W-1:0]   out_mac_r, out_mac_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic               out_evicted_r, out_evicted_nxt;
  logic               cur_match;
  logic               cur_free;
  logic [IDX_W-1:0]   wr_idx;
  logic               ip_we;
  logic               mac_we;

  logic [IP_W-1:0]    ip_mem  [ENTRIES];
  logic [MAC_W-1:0]   mac_mem [ENTRIES];

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_mac_result = out_mac_r;
  assign out_slot       = out_slot_r;
  assign out_evicted    = out_evicted_r;

  assign cur_match = chk_vld_r && valid_r[chk_idx_r] && (ip_rd_r == item_r.ip);
  assign cur_free  = chk_vld_r && !valid_r[chk_idx_r];
  assign wr_idx    = hit_r ? hit_idx_r : (free_r ? free_idx_r : '0);
  assign q_pop     = (state_r == S_IDLE) && !q_status.empty;
  assign mac_we    = (state_r == S_EXEC) && (item_r.op == OP_LEARN);
  assign ip_we     = mac_we && !hit_r;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    chk_vld_nxt     = (state_r == S_SCAN);
    chk_idx_nxt     = idx_r;
    valid_nxt       = valid_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    out_valid_nxt   = 1'b0;
    out_found_nxt   = 1'b0;
    out_mac_nxt     = '0;
    out_slot_nxt    = '0;
    out_evicted_nxt = 1'b0;

    if (cur_match && !hit_r) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = chk_idx_r;
    end
    if (cur_free && !free_r) begin
      free_nxt     = 1'b1;
      free_idx_nxt = chk_idx_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (!q_status.empty) begin
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (item_r.op == OP_LEARN) begin
          out_valid_nxt   = 1'b1;
          out_found_nxt   = hit_r;
          out_mac_nxt     = item_r.mac;
          out_slot_nxt    = slot_of(wr_idx);
          out_evicted_nxt = !hit_r && !free_r;
          valid_nxt[wr_idx] = 1'b1;
          state_nxt       = S_IDLE;
        end else if (hit_r) begin
          state_nxt = S_MAC;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MAC: begin
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b1;
        out_mac_nxt   = mac_rd_r;
        out_slot_nxt  = slot_of(hit_idx_r);
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      valid_r     <= valid_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    if (q_pop) begin
      item_r <= q_item;
    end
    if (out_valid_nxt) begin
      out_found_r   <= out_found_nxt;
      out_mac_r     <= out_mac_nxt;
      out_slot_r    <= out_slot_nxt;
      out_evicted_r <= out_evicted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ip_we) begin
      ip_mem[wr_idx] <= item_r.ip;
    end
    ip_rd_r <= ip_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (mac_we) begin
      mac_mem[wr_idx] <= item_r.mac;
    end
    mac_rd_r <= mac_mem[hit_idx_r];
  end

endmodule

### design/arp_cache_table_top.sv
`timescale 1ns / 1ps
// An accepted start passes through the input holding register and the queue; the back end then
// scans every slot, drains the last address read and executes, and a lookup hit adds a MAC read.
// The back end works on one item at a time and pops the next only from idle; the slot scan
// reads one address entry per cycle from the address store.
// A two-entry queue and an input holding register let start be taken while a scan runs.
// Synchronous active-low reset clears all valid marks; results cannot be stalled.

module arp_cache_table_top
  import arp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_kind,
  input  logic [IP_W-1:0]   in_ip_addr,
  input  logic [MAC_W-1:0]  in_mac_addr,
  output logic              out_valid,
  output logic              out_found,
  output logic [MAC_W-1:0]  out_mac_result,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_evicted
);

  q_status_t q_status;
  logic      q_push;
  item_t     q_push_item;
  logic      q_pop;
  item_t     q_pop_item;

  arp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_ip_addr  (in_ip_addr),
    .in_mac_addr (in_mac_addr),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_item      (q_push_item)
  );

  arp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .status    (q_status)
  );

  arp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .q_item         (q_pop_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_mac_result (out_mac_result),
    .out_slot       (out_slot),
    .out_evicted    (out_evicted)
  );

endmodule
